### sv/mpps_pkg.sv
package mpps_pkg;

  localparam int NUM_ENTRIES = 8;
  localparam int MAX_CORES   = 4;
  localparam int TIME_BITS   = 16;
  localparam int IDX_BITS    = 3;
  localparam int CNT_BITS    = 4;

  localparam logic [2:0] POL_FCFS = 3'd0;
  localparam logic [2:0] POL_SJF  = 3'd1;
  localparam logic [2:0] POL_SRT  = 3'd2;
  localparam logic [2:0] POL_RR   = 3'd3;
  localparam logic [2:0] POL_PRIO = 3'd4;
  localparam logic [2:0] POL_EDF  = 3'd5;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_CORES  = 2'd1;
  localparam logic [1:0] REG_SLICE  = 2'd2;
  localparam logic [1:0] REG_COUNT  = 2'd3;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  entry_index;
    logic [15:0] arrival_time;
    logic [15:0] run_length;
    logic [15:0] due_time;
    logic [7:0]  priority_level;
  } req_t;

  typedef struct packed {
    logic [7:0] running_mask;
    logic [7:0] started_mask;
    logic [7:0] finished_mask;
    logic       all_done;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TICK, S_FIN, S_CAND, S_RANK, S_WALK, S_MID, S_EXP, S_OUT
  } state_t;

  typedef struct packed {
    logic                load;
    logic                tick;
    logic                fin;
    logic                cand;
    logic                rank_step;
    logic                walk_step;
    logic                clr_jr;
    logic                exp_step;
    logic                publish;
    logic [IDX_BITS-1:0] idx;
    logic                pass;
  } cmd_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] n;
    logic                two_pass;
    logic                out_free;
  } status_t;

endpackage

### sv/multi_policy_process_scheduler.sv
// Load beat: written into the entry tables straight from idle, no result.
// Tick beat: tick, finish and candidate states, the rank pass, the dispatch walk (twice in
// priority mode), a middle state and the slice walk over the n entries in use, one rank per
// cycle, then the output state; the next beat is taken in the cycle the result turns valid.
// Input stalls until the result is registered; a result may wait while the next beat is taken.
// Synchronous reset clears configuration to its defaults, time, flags and the output valid.
module multi_policy_process_scheduler import mpps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output rsp_t        out_data
);

  cmd_t    cmd;
  status_t status;

  mpps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_is_tick (in_data.req_type),
    .in_stall   (in_stall),
    .status     (status),
    .cmd        (cmd)
  );

  mpps_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sv/mpps_ctrl.sv
module mpps_ctrl import mpps_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_is_tick,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t              state, state_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  logic                pass, pass_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pass  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pass  <= pass_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pass_next  = pass;
    cmd        = '0;
    cmd.idx    = cnt[IDX_BITS-1:0];
    cmd.pass   = pass;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_is_tick == REQ_TICK) state_next = S_TICK;
          else cmd.load = 1'b1;
        end
      end
      S_TICK: begin
        cmd.tick   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.fin    = 1'b1;
        state_next = S_CAND;
      end
      S_CAND: begin
        cmd.cand   = 1'b1;
        cnt_next   = '0;
        state_next = S_RANK;
      end
      S_RANK: begin
        if (cnt < status.n) begin
          cmd.rank_step = 1'b1;
          cnt_next      = cnt + 1'b1;
        end else begin
          cnt_next   = '0;
          pass_next  = 1'b0;
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (cnt < status.n) begin
          cmd.walk_step = 1'b1;
          cnt_next      = cnt + 1'b1;
        end else if (status.two_pass && !pass) begin
          pass_next = 1'b1;
          cnt_next  = '0;
        end else begin
          state_next = S_MID;
        end
      end
      S_MID: begin
        cmd.clr_jr = 1'b1;
        cnt_next   = '0;
        state_next = S_EXP;
      end
      S_EXP: begin
        if (cnt < status.n) begin
          cmd.exp_step = 1'b1;
          cnt_next     = cnt + 1'b1;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### sv/mpps_dp.sv
module mpps_dp import mpps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  req_t        in_data,
  input  cmd_t        cmd,
  output status_t     status,
  output logic        out_valid,
  input  logic        out_stall,
  output rsp_t        out_data
);

  localparam int E = NUM_ENTRIES;
  localparam int T = TIME_BITS;

  logic [2:0]  policy, cores_cfg;
  logic [15:0] slice_cfg;
  logic [3:0]  count_cfg;

  logic [T-1:0] now;
  logic [T-1:0] arr [E];
  logic [T-1:0] rem [E];
  logic [T-1:0] dl  [E];
  logic [7:0]   pri [E];
  logic [T-1:0] ss  [E];
  logic [E-1:0] run, done, jr, started, cand;
  logic [IDX_BITS-1:0] rank [E];
  logic [IDX_BITS-1:0] rot, rotl;
  logic [CNT_BITS-1:0] nrun;

  logic [CNT_BITS-1:0] n;
  logic [E-1:0]        nmask;
  logic [2:0]          cores;
  logic [15:0]         slice;
  logic [T-1:0]        key [E];
  logic [CNT_BITS-1:0] pos;
  logic [E-1:0]        sel;
  logic [T-1:0]        ksel, ssel, kj, vk;
  logic [E-1:0]        vsel;
  logic                vfound;
  logic                is_cand, jr_sel, can_run, do_disp, do_preempt;
  logic [E-1:0]        run_masked;
  logic [CNT_BITS-1:0] run_cnt;
  logic [CNT_BITS-1:0] p1;
  logic                expire;

  always_comb begin
    n = (count_cfg > CNT_BITS'(E)) ? CNT_BITS'(E) : count_cfg;
    for (int i = 0; i < E; i++) nmask[i] = (CNT_BITS'(i) < n);
    cores = (cores_cfg == 3'd0) ? 3'd1 :
            ((cores_cfg > 3'(MAX_CORES)) ? 3'(MAX_CORES) : cores_cfg);
    slice = (slice_cfg == 16'd0) ? 16'd1 : slice_cfg;
    for (int i = 0; i < E; i++) begin
      case (policy)
        POL_SJF, POL_SRT: key[i] = rem[i];
        POL_PRIO:         key[i] = T'(~pri[i]);
        POL_EDF:          key[i] = dl[i];
        default:          key[i] = arr[i];
      endcase
    end
    run_masked = run & nmask;
    run_cnt = '0;
    for (int i = 0; i < E; i++) run_cnt = run_cnt + CNT_BITS'(run_masked[i]);

    // walk position; round robin rotates from the latched pointer
    pos = {1'b0, cmd.idx};
    if (policy == POL_RR && cmd.walk_step) begin
      pos = {1'b0, rotl} + {1'b0, cmd.idx};
      if (pos >= n) pos = pos - n;
    end
    ksel = '0;
    ssel = '0;
    for (int i = 0; i < E; i++) begin
      sel[i] = nmask[i] && (rank[i] == pos[IDX_BITS-1:0]);
      if (sel[i]) begin
        ksel = ksel | key[i];
        ssel = ssel | ss[i];
      end
    end
    kj = key[cmd.idx];

    // victim: running entry with largest key, ties to higher index
    vfound = 1'b0;
    vk     = '0;
    vsel   = '0;
    for (int j = 0; j < E; j++) begin
      if (run_masked[j] && (!vfound || key[j] >= vk)) begin
        vfound = 1'b1;
        vk     = key[j];
        vsel   = '0;
        vsel[j] = 1'b1;
      end
    end

    is_cand = |(cand & sel);
    jr_sel  = |(jr & sel);
    can_run = (nrun < {1'b0, cores});
    do_disp = 1'b0;
    do_preempt = 1'b0;
    if (cmd.walk_step && is_cand) begin
      case (policy)
        POL_SRT, POL_EDF: begin
          if (can_run) do_disp = 1'b1;
          else if (vfound && ksel < vk) begin
            do_disp    = 1'b1;
            do_preempt = 1'b1;
          end
        end
        POL_PRIO: do_disp = can_run && (jr_sel == cmd.pass);
        default:  do_disp = can_run;
      endcase
    end

    p1 = {1'b0, cmd.idx} + 1'b1;
    expire = cmd.exp_step && (policy == POL_RR || policy == POL_PRIO) &&
             (|(run & sel)) && ((now - ssel) >= T'(slice));

    status.n        = n;
    status.two_pass = (policy == POL_PRIO);
    status.out_free = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy    <= POL_FCFS;
      cores_cfg <= 3'd1;
      slice_cfg <= 16'd5;
      count_cfg <= 4'd0;
      now       <= '0;
      run       <= '0;
      done      <= '0;
      jr        <= '0;
      started   <= '0;
      rot       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_POLICY: policy    <= cfg_data[2:0];
          REG_CORES:  cores_cfg <= cfg_data[2:0];
          REG_SLICE:  slice_cfg <= cfg_data;
          REG_COUNT:  count_cfg <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        run[in_data.entry_index]  <= 1'b0;
        done[in_data.entry_index] <= 1'b0;
        jr[in_data.entry_index]   <= 1'b0;
      end
      if (cmd.tick) begin
        now     <= now + 1'b1;
        run     <= run & nmask;
        started <= '0;
      end
      if (cmd.fin) begin
        for (int i = 0; i < E; i++) begin
          if (nmask[i] && !done[i] && rem[i] == '0) begin
            done[i] <= 1'b1;
            run[i]  <= 1'b0;
          end
        end
      end
      if (do_disp) begin
        run     <= (run & ~(do_preempt ? vsel : '0)) | sel;
        started <= started | sel;
      end
      if (cmd.clr_jr && policy == POL_PRIO) jr <= '0;
      if (expire) begin
        run <= run & ~sel;
        if (policy == POL_PRIO) jr <= jr | sel;
        else rot <= (p1 >= n) ? '0 : p1[IDX_BITS-1:0];
      end
      if (cmd.publish) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arr[in_data.entry_index] <= in_data.arrival_time;
      rem[in_data.entry_index] <= in_data.run_length;
      dl[in_data.entry_index]  <= in_data.due_time;
      pri[in_data.entry_index] <= in_data.priority_level;
      ss[in_data.entry_index]  <= '0;
    end
    if (cmd.tick) begin
      for (int i = 0; i < E; i++)
        if (run_masked[i] && rem[i] != '0) rem[i] <= rem[i] - 1'b1;
    end
    if (cmd.cand) begin
      for (int i = 0; i < E; i++) begin
        cand[i] <= nmask[i] && !done[i] && !run[i] && (arr[i] <= now);
        rank[i] <= '0;
      end
      nrun <= run_cnt;
      rotl <= ({1'b0, rot} < n) ? rot : '0;
    end
    // stable rank: count entries with smaller key, ties to lower index
    if (cmd.rank_step) begin
      for (int i = 0; i < E; i++)
        if (kj < key[i] || (kj == key[i] && cmd.idx < IDX_BITS'(i)))
          rank[i] <= rank[i] + 1'b1;
    end
    if (do_disp) begin
      for (int i = 0; i < E; i++) if (sel[i]) ss[i] <= now;
      if (!do_preempt) nrun <= nrun + 1'b1;
    end
    if (cmd.publish) begin
      out_data.running_mask  <= run & nmask;
      out_data.started_mask  <= started;
      out_data.finished_mask <= done & nmask;
      out_data.all_done      <= ((done & nmask) == nmask);
    end
  end

endmodule
